/* rtl/core/gclw_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph code lookup package
// Field widths, request codes, string-end codes and controller states shared
// by the glyph code lookup block.
// ----------------------------------------------------------------------------
package gclw_pkg;

    // Default number of table entries
    localparam int TABLE_DEPTH_DEF = 1024;

    // Field widths
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int CODE_W  = 16;
    localparam int ADV_W   = 16;

    // Request types
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Codes that terminate a string
    localparam logic [CODE_W-1:0] CODE_NUL = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_CR  = 16'h000D;
    localparam logic [CODE_W-1:0] CODE_LF  = 16'h000A;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } gclw_state_t;

endpackage

/* rtl/core/gclw_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data appears in the cycle
// after the address is presented with rd_en high.
// ----------------------------------------------------------------------------
module gclw_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/glyph_code_lookup_width.sv */
// ----------------------------------------------------------------------------
// Glyph code lookup with string width
// Sorted code table with per-glyph advance; binary search per lookup and a
// running string width that clears on a string-end code (0, CR or LF).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): a load transfer writes code and advance
//   at s_entry_index; a lookup transfer searches the first glyph_count
//   entries (saturated to the table depth) for s_char_code.
//   Result channel (m_valid/m_ready): one result per input transfer, in order.
//   cfg_wr_en/cfg_wr_data set glyph_count; write it only while idle.
//   Flow: a load, a string end (code 0, CR or LF) or a lookup on an empty
//   table goes from acceptance straight to the done state. A lookup makes P
//   table probes first, P at most ceil(log2(count + 1)), i.e. 11 for 1024
//   entries. One item is in flight at a time; a new item is taken only once
//   the previous one has left the controller for the output register. Each
//   probe is one read of the table RAM, whose registered read paces the loop.
//   The result sits in an output register, so the next item is accepted while
//   a result waits; if the receiver stalls longer, the finished item holds in
//   the controller and s_ready stays low.
//   Reset clears glyph_count, the width accumulator and all valids. The table
//   itself is not cleared; entries must be loaded before they are searched.
// ----------------------------------------------------------------------------
module glyph_code_lookup_width #(
    parameter int TABLE_DEPTH = gclw_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic [gclw_pkg::COUNT_W-1:0]  cfg_wr_data,
    // Input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [gclw_pkg::INDEX_W-1:0]  s_entry_index,
    input  logic [gclw_pkg::CODE_W-1:0]   s_char_code,
    input  logic [gclw_pkg::ADV_W-1:0]    s_entry_advance,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [gclw_pkg::INDEX_W-1:0]  m_glyph_index,
    output logic [gclw_pkg::ADV_W-1:0]    m_glyph_advance,
    output logic [gclw_pkg::ADV_W-1:0]    m_string_width,
    output logic                          m_string_end
);

    import gclw_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = CODE_W + ADV_W;

    // State and registers
    gclw_state_t         state_reg, state_next;
    logic [COUNT_W-1:0]  glyph_count_reg, glyph_count_next;
    logic [ADV_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hx_reg, hx_next;
    logic [ADDR_W-1:0]   mid_reg, mid_next;
    logic [CODE_W-1:0]   code_reg, code_next;

    // Finished result waiting for the output register
    logic                res_found_reg, res_found_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [ADV_W-1:0]    res_adv_reg, res_adv_next;
    logic [ADV_W-1:0]    res_width_reg, res_width_next;
    logic                res_end_reg, res_end_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic                m_found_reg, m_found_next;
    logic [INDEX_W-1:0]  m_index_reg, m_index_next;
    logic [ADV_W-1:0]    m_adv_reg, m_adv_next;
    logic [ADV_W-1:0]    m_width_reg, m_width_next;
    logic                m_end_reg, m_end_next;

    // RAM port signals
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    // Decode helpers
    logic                s_accept;
    logic                s_is_end;
    logic [CNT_W-1:0]    n_sat;
    logic [ADDR_W-1:0]   mid_init;
    logic [CODE_W-1:0]   probe_code;
    logic [ADV_W-1:0]    probe_adv;
    logic [ADV_W-1:0]    acc_sum;
    logic [CNT_W-1:0]    mid_ext;
    logic [CNT_W-1:0]    mid_inc;
    logic [ADDR_W-1:0]   mid_lower;
    logic [ADDR_W-1:0]   mid_upper;

    // Code and advance table
    gclw_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Handshake and decode
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign s_is_end = (s_char_code == CODE_NUL) || (s_char_code == CODE_CR) ||
                      (s_char_code == CODE_LF);

    // Searched entry count, saturated to the table depth
    assign n_sat = (32'(glyph_count_reg) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(glyph_count_reg);
    assign mid_init = ADDR_W'((SUM_W'(n_sat) - SUM_W'(1)) >> 1);

    // Probe data and candidate next midpoints
    assign probe_code = ram_rd_data[DATA_W-1:ADV_W];
    assign probe_adv  = ram_rd_data[ADV_W-1:0];
    assign acc_sum    = acc_reg + probe_adv;
    assign mid_ext    = CNT_W'(mid_reg);
    assign mid_inc    = mid_ext + CNT_W'(1);
    assign mid_lower  = ADDR_W'((SUM_W'(lo_reg) + SUM_W'(mid_reg) - SUM_W'(1)) >> 1);
    assign mid_upper  = ADDR_W'((SUM_W'(mid_reg) + SUM_W'(hx_reg)) >> 1);

    // Controller
    always_comb begin
        state_next       = state_reg;
        glyph_count_next = glyph_count_reg;
        acc_next         = acc_reg;
        lo_next          = lo_reg;
        hx_next          = hx_reg;
        mid_next         = mid_reg;
        code_next        = code_reg;
        res_found_next   = res_found_reg;
        res_index_next   = res_index_reg;
        res_adv_next     = res_adv_reg;
        res_width_next   = res_width_reg;
        res_end_next     = res_end_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_found_next     = m_found_reg;
        m_index_next     = m_index_reg;
        m_adv_next       = m_adv_reg;
        m_width_next     = m_width_reg;
        m_end_next       = m_end_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = ADDR_W'(s_entry_index);
        ram_wr_data      = {s_char_code, s_entry_advance};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = mid_init;

        // Register write
        if (cfg_wr_en) begin
            glyph_count_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    res_adv_next   = '0;
                    res_width_next = acc_reg;
                    res_end_next   = 1'b0;
                    if (s_req_type == REQ_LOAD) begin
                        ram_wr_en  = (32'(s_entry_index) < 32'(TABLE_DEPTH));
                        state_next = ST_DONE;
                    end else if (s_is_end) begin
                        res_end_next = 1'b1;
                        acc_next     = '0;
                        state_next   = ST_DONE;
                    end else if (n_sat == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        // Start search, first probe address goes out now
                        lo_next    = '0;
                        hx_next    = n_sat;
                        mid_next   = mid_init;
                        code_next  = s_char_code;
                        ram_rd_en  = 1'b1;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (probe_code == code_reg) begin
                    res_found_next = 1'b1;
                    res_index_next = INDEX_W'(mid_reg);
                    res_adv_next   = probe_adv;
                    res_width_next = acc_sum;
                    acc_next       = acc_sum;
                    state_next     = ST_DONE;
                end else if (probe_code > code_reg) begin
                    // Continue in the lower half
                    hx_next     = mid_ext;
                    mid_next    = mid_lower;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid_lower;
                    if (lo_reg >= mid_ext) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    // Continue in the upper half
                    lo_next     = mid_inc;
                    mid_next    = mid_upper;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid_upper;
                    if (mid_inc >= hx_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_index_next = res_index_reg;
                    m_adv_next   = res_adv_reg;
                    m_width_next = res_width_reg;
                    m_end_next   = res_end_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            glyph_count_reg <= '0;
            acc_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            glyph_count_reg <= glyph_count_next;
            acc_reg         <= acc_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hx_reg        <= hx_next;
        mid_reg       <= mid_next;
        code_reg      <= code_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        res_adv_reg   <= res_adv_next;
        res_width_reg <= res_width_next;
        res_end_reg   <= res_end_next;
        m_found_reg   <= m_found_next;
        m_index_reg   <= m_index_next;
        m_adv_reg     <= m_adv_next;
        m_width_reg   <= m_width_next;
        m_end_reg     <= m_end_next;
    end

    // Outputs
    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_glyph_index   = m_index_reg;
    assign m_glyph_advance = m_adv_reg;
    assign m_string_width  = m_width_reg;
    assign m_string_end    = m_end_reg;

`ifndef NO_ASSERTIONS
    // Search window is never empty while a probe is outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> (lo_reg < hx_reg))
        else $error("search window empty during probe");

    // Probe address lies inside the search window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> ((mid_ext >= lo_reg) && (mid_ext < hx_reg)))
        else $error("probe address outside search window");

    // A string end transfer clears the accumulator
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_req_type == REQ_LOOKUP) && s_is_end) |=> (acc_reg == '0))
        else $error("accumulator not cleared on string end");

    // A hit is never a string end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_found_reg |-> !m_end_reg)
        else $error("hit reported together with string end");

    // A miss reports zero index and advance
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> ((m_index_reg == '0) && (m_adv_reg == '0)))
        else $error("miss with nonzero index or advance");
`endif

endmodule
